>>> hdl/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;
    localparam int NUM_FRAMES = 1024;
    localparam int FW         = $clog2(NUM_FRAMES);

    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_RESERVE = 2'd1;
    localparam logic [1:0] FN_FREE    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOBLOCK  = 2'd1;
    localparam logic [1:0] ST_BADFRAME = 2'd2;

    localparam logic [2:0] MARK_INNER = 3'd4;
    localparam logic [2:0] MARK_ALLOC = 3'd5;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DECODE,
        S_AL_SCAN, S_AL_UNLINK, S_AL_SPLIT,
        S_RS_PROBE, S_RS_CHECK, S_RS_UNLINK, S_RS_SPLIT,
        S_FR_CHECK, S_FR_CHKRD, S_FR_CLEAR, S_FR_BUD, S_FR_BUDRD,
        S_FR_BUDUNL, S_FR_FINAL,
        S_MF_MARK, S_MF_HEAD, S_MF_PUSH,
        S_MA_MARK, S_UNL_RD, S_UNL_WR1, S_UNL_WR2,
        S_DONE
    } t_state;
endpackage

>>> hdl/bpa_datapath.sv
// Datapath of the buddy page allocator: mark store plus next and prev link stores.
`timescale 1ns / 1ps
module bpa_datapath (
    input  logic                  i_clk,
    input  logic                  i_mark_we,
    input  logic [bpa_pkg::FW-1:0] i_mark_addr,
    input  logic [2:0]            i_mark_wd,
    output logic [2:0]            o_mark_rd,
    input  logic                  i_next_we,
    input  logic [bpa_pkg::FW-1:0] i_next_waddr,
    input  logic [bpa_pkg::FW:0]   i_next_wd,
    input  logic [bpa_pkg::FW-1:0] i_next_raddr,
    output logic [bpa_pkg::FW:0]   o_next_rd,
    input  logic                  i_prev_we,
    input  logic [bpa_pkg::FW-1:0] i_prev_waddr,
    input  logic [bpa_pkg::FW:0]   i_prev_wd,
    input  logic [bpa_pkg::FW-1:0] i_prev_raddr,
    output logic [bpa_pkg::FW:0]   o_prev_rd
);
    import bpa_pkg::*;

    // mark store: one port, registered read returns the old data on a write
    logic [2:0]  r_mark [2**FW];
    logic [FW:0] r_next [2**FW];
    logic [FW:0] r_prev [2**FW];

    always_ff @(posedge i_clk) begin
        if (i_mark_we) begin
            r_mark[i_mark_addr] <= i_mark_wd;
        end
        o_mark_rd <= r_mark[i_mark_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_next_we) begin
            r_next[i_next_waddr] <= i_next_wd;
        end
        o_next_rd <= r_next[i_next_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_prev_we) begin
            r_prev[i_prev_waddr] <= i_prev_wd;
        end
        o_prev_rd <= r_prev[i_prev_raddr];
    end
endmodule

>>> hdl/bpa_ctrl.sv
// Sequencer of the buddy page allocator: walks marks and free lists one step a cycle, held in S_DONE by back-pressure.
`timescale 1ns / 1ps
module bpa_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_func,
    input  logic [1:0]             i_order,
    input  logic [9:0]             i_frame,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [9:0]             o_start,
    output logic [1:0]             o_status,
    output logic [10:0]            o_count,
    output logic                   o_mark_we,
    output logic [bpa_pkg::FW-1:0] o_mark_addr,
    output logic [2:0]             o_mark_wd,
    input  logic [2:0]             i_mark_rd,
    output logic                   o_next_we,
    output logic [bpa_pkg::FW-1:0] o_next_waddr,
    output logic [bpa_pkg::FW:0]   o_next_wd,
    output logic [bpa_pkg::FW-1:0] o_next_raddr,
    input  logic [bpa_pkg::FW:0]   i_next_rd,
    output logic                   o_prev_we,
    output logic [bpa_pkg::FW-1:0] o_prev_waddr,
    output logic [bpa_pkg::FW:0]   o_prev_wd,
    output logic [bpa_pkg::FW-1:0] o_prev_raddr,
    input  logic [bpa_pkg::FW:0]   i_prev_rd
);
    import bpa_pkg::*;

    localparam logic [FW:0] NIL = (FW+1)'(NUM_FRAMES);
    localparam int NBLK = NUM_FRAMES / 8;

    t_state r_state, n_state;
    t_state r_mret, n_mret;       // return point after make_free / unlink
    logic [FW:0] r_ptr, n_ptr;    // init sweep counter
    logic [FW:0] r_head [4];
    logic [FW:0] n_head [4];
    logic [1:0]  r_func, n_func, r_k, n_k, r_j, n_j, r_mk, n_mk;
    logic [FW:0] r_f, n_f, r_b, n_b, r_mb, n_mb, r_ub, n_ub, r_p, n_p;
    logic [1:0]  r_uk, n_uk;
    logic [3:0]  r_i, n_i;
    logic [9:0]  r_start, n_start;
    logic [1:0]  r_status, n_status;
    logic [10:0] r_count, n_count;
    logic        r_ovalid, n_ovalid;
    logic [9:0]  r_ostart, n_ostart;
    logic [1:0]  r_ostatus, n_ostatus;
    logic [10:0] r_ocount, n_ocount;
    logic [FW:0] w_sz, w_bud;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_start  = r_ostart;
    assign o_status = r_ostatus;
    assign o_count  = r_ocount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ptr    <= '0;
            r_ovalid <= 1'b0;
            r_count  <= '0;
            for (int q = 0; q < 4; q++) r_head[q] <= NIL;
            r_mret <= S_IDLE;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_ovalid <= n_ovalid;
            r_count  <= n_count;
            r_head   <= n_head;
            r_mret   <= n_mret;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func; r_k <= n_k; r_j <= n_j; r_f <= n_f; r_b <= n_b;
        r_mb <= n_mb; r_mk <= n_mk; r_ub <= n_ub; r_uk <= n_uk; r_p <= n_p;
        r_i <= n_i; r_start <= n_start; r_status <= n_status;
        r_ostart <= n_ostart; r_ostatus <= n_ostatus; r_ocount <= n_ocount;
    end

    assign w_sz  = (FW+1)'(1) << r_j;
    assign w_bud = r_b ^ w_sz;

    always_comb begin
        n_state = r_state; n_mret = r_mret; n_ptr = r_ptr; n_head = r_head;
        n_func = r_func; n_k = r_k; n_j = r_j; n_f = r_f; n_b = r_b;
        n_mb = r_mb; n_mk = r_mk; n_ub = r_ub; n_uk = r_uk; n_p = r_p;
        n_i = r_i; n_start = r_start; n_status = r_status; n_count = r_count;
        n_ovalid = r_ovalid;
        n_ostart = r_ostart; n_ostatus = r_ostatus; n_ocount = r_ocount;
        o_mark_we = 1'b0; o_mark_addr = r_f[FW-1:0]; o_mark_wd = MARK_INNER;
        o_next_we = 1'b0; o_next_waddr = r_ub[FW-1:0]; o_next_wd = NIL;
        o_next_raddr = r_ub[FW-1:0];
        o_prev_we = 1'b0; o_prev_waddr = r_ub[FW-1:0]; o_prev_wd = NIL;
        o_prev_raddr = r_ub[FW-1:0];
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_state)
            S_INIT: begin
                // one frame per cycle: marks and block chain
                o_mark_we = 1'b1;
                o_mark_addr = r_ptr[FW-1:0];
                o_mark_wd = (r_ptr[2:0] == 3'd0 && r_ptr + 8 <= NIL) ? 3'd3 : MARK_INNER;
                o_next_we = 1'b1; o_next_waddr = r_ptr[FW-1:0];
                o_next_wd = (r_ptr[2:0] == 3'd0 && r_ptr + 16 <= NIL) ?
                            r_ptr + (FW+1)'(8) : NIL;
                o_prev_we = 1'b1; o_prev_waddr = r_ptr[FW-1:0];
                o_prev_wd = (r_ptr[2:0] == 3'd0 && r_ptr != 0) ?
                            r_ptr - (FW+1)'(8) : NIL;
                if (r_ptr == NIL - 1) begin
                    n_state = S_IDLE;
                    if (NBLK > 0) n_head[3] = '0;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_func = i_func; n_k = i_order; n_j = i_order;
                    n_f = {1'b0, i_frame}; n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_start = '0;
                n_status = ST_OK;
                if (r_func == FN_ALLOC) begin
                    n_state = S_AL_SCAN;
                end else if (r_func == FN_RESERVE) begin
                    if (r_f >= NIL) begin
                        n_status = ST_BADFRAME; n_state = S_DONE;
                    end else begin
                        n_b = r_f & ~((FW+1)'((1 << r_j) - 1));
                        n_state = S_RS_PROBE;
                    end
                end else if (r_func == FN_FREE) begin
                    if (r_f >= NIL || (r_f & (FW+1)'((1 << r_k) - 1)) != 0 ||
                        r_f + ((FW+1)'(1) << r_k) > NIL) begin
                        n_status = ST_BADFRAME; n_state = S_DONE;
                    end else begin
                        n_i = '0; n_state = S_FR_CHECK;
                    end
                end else begin
                    n_status = ST_BADFRAME; n_state = S_DONE;
                end
            end
            S_AL_SCAN: begin
                if (r_head[r_j] < NIL) begin
                    n_b = r_head[r_j]; n_ub = r_head[r_j]; n_uk = r_j;
                    n_mret = S_AL_SPLIT; n_state = S_UNL_RD;
                end else if (r_j == 2'd3) begin
                    n_status = ST_NOBLOCK; n_state = S_DONE;
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            S_AL_SPLIT: begin
                if (r_j > r_k) begin
                    n_j = r_j - 2'd1;
                    n_mb = r_b + ((FW+1)'(1) << (r_j - 2'd1)); n_mk = r_j - 2'd1;
                    n_i = 4'd1; n_mret = S_AL_SPLIT; n_state = S_MF_MARK;
                end else begin
                    n_i = '0; n_state = S_MA_MARK;
                end
            end
            S_RS_PROBE: begin
                o_mark_addr = r_b[FW-1:0];
                n_state = S_RS_CHECK;
            end
            S_RS_CHECK: begin
                o_mark_addr = r_b[FW-1:0];
                if (i_mark_rd == {1'b0, r_j}) begin
                    n_ub = r_b; n_uk = r_j; n_mret = S_RS_SPLIT; n_state = S_UNL_RD;
                end else if (r_j == 2'd3) begin
                    n_status = ST_NOBLOCK; n_state = S_DONE;
                end else begin
                    n_j = r_j + 2'd1;
                    n_b = r_f & ~((FW+1)'((2 << r_j) - 1));
                    n_state = S_RS_PROBE;
                end
            end
            S_RS_SPLIT: begin
                if (r_j > r_k) begin
                    n_j = r_j - 2'd1; n_mk = r_j - 2'd1; n_i = 4'd1;
                    n_mret = S_RS_SPLIT; n_state = S_MF_MARK;
                    if (r_f[r_j - 2'd1]) begin
                        n_mb = r_b; n_b = r_b + ((FW+1)'(1) << (r_j - 2'd1));
                    end else begin
                        n_mb = r_b + ((FW+1)'(1) << (r_j - 2'd1));
                    end
                end else begin
                    n_i = '0; n_state = S_MA_MARK;
                end
            end
            S_FR_CHECK: begin
                o_mark_addr = FW'(r_f + FW'(r_i));
                n_state = S_FR_CHKRD;
            end
            S_FR_CHKRD: begin
                o_mark_addr = FW'(r_f + FW'(r_i));
                if (i_mark_rd != MARK_ALLOC) begin
                    n_status = ST_BADFRAME; n_state = S_DONE;
                end else if ({1'b0, r_i} + 5'd1 == (5'd1 << r_k)) begin
                    n_i = '0; n_state = S_FR_CLEAR;
                end else begin
                    n_i = r_i + 4'd1; n_state = S_FR_CHECK;
                end
            end
            S_FR_CLEAR: begin
                o_mark_we = 1'b1; o_mark_addr = FW'(r_f + FW'(r_i));
                o_mark_wd = MARK_INNER;
                if ({1'b0, r_i} + 5'd1 == (5'd1 << r_k)) begin
                    n_count = r_count - (11'd1 << r_k);
                    n_b = r_f; n_j = r_k; n_state = S_FR_BUD;
                end else begin
                    n_i = r_i + 4'd1;
                end
            end
            S_FR_BUD: begin
                o_mark_addr = w_bud[FW-1:0];
                if (r_j == 2'd3 || w_bud >= NIL) n_state = S_FR_FINAL;
                else n_state = S_FR_BUDRD;
            end
            S_FR_BUDRD: begin
                o_mark_addr = w_bud[FW-1:0];
                if (i_mark_rd != {1'b0, r_j}) begin
                    n_state = S_FR_FINAL;
                end else begin
                    n_ub = w_bud; n_uk = r_j; n_mret = S_FR_BUDUNL; n_state = S_UNL_RD;
                end
            end
            S_FR_BUDUNL: begin
                o_mark_we = 1'b1; o_mark_addr = r_ub[FW-1:0]; o_mark_wd = MARK_INNER;
                if (r_ub < r_b) n_b = r_ub;
                n_j = r_j + 2'd1; n_state = S_FR_BUD;
            end
            S_FR_FINAL: begin
                n_mb = r_b; n_mk = r_j; n_i = 4'd1;
                n_start = r_f[9:0]; n_mret = S_DONE; n_state = S_MF_MARK;
            end
            // make_free: inner marks, head mark, push
            S_MF_MARK: begin
                if ({1'b0, r_i} >= (5'd1 << r_mk)) begin
                    n_state = S_MF_HEAD;
                end else begin
                    o_mark_we = 1'b1; o_mark_addr = FW'(r_mb + FW'(r_i));
                    o_mark_wd = MARK_INNER; n_i = r_i + 4'd1;
                end
            end
            S_MF_HEAD: begin
                o_mark_we = 1'b1; o_mark_addr = r_mb[FW-1:0]; o_mark_wd = {1'b0, r_mk};
                n_state = S_MF_PUSH;
            end
            S_MF_PUSH: begin
                o_prev_we = 1'b1; o_prev_waddr = r_mb[FW-1:0]; o_prev_wd = NIL;
                o_next_we = 1'b1; o_next_waddr = r_mb[FW-1:0];
                o_next_wd = r_head[r_mk];
                n_head[r_mk] = r_mb;
                n_p = r_head[r_mk];
                n_state = S_UNL_WR2; n_ub = NIL;    // fix prev of old head
                n_uk = r_mk;
            end
            S_MA_MARK: begin
                o_mark_we = 1'b1; o_mark_addr = FW'(r_b + FW'(r_i));
                o_mark_wd = MARK_ALLOC;
                if ({1'b0, r_i} + 5'd1 == (5'd1 << r_k)) begin
                    n_count = r_count + (11'd1 << r_k);
                    n_start = r_b[9:0]; n_state = S_DONE;
                end else begin
                    n_i = r_i + 4'd1;
                end
            end
            S_UNL_RD: begin
                n_state = S_UNL_WR1;
            end
            S_UNL_WR1: begin
                // i_prev_rd = p, i_next_rd = n of r_ub
                n_p = i_next_rd;
                if (i_prev_rd < NIL) begin
                    o_next_we = 1'b1; o_next_waddr = i_prev_rd[FW-1:0];
                    o_next_wd = i_next_rd;
                end else begin
                    n_head[r_uk] = i_next_rd;
                end
                n_mb = i_prev_rd;
                n_state = S_UNL_WR2;
            end
            S_UNL_WR2: begin
                // r_p: node whose prev gets r_mb (unlink) or pushed head (push)
                if (r_p < NIL) begin
                    o_prev_we = 1'b1; o_prev_waddr = r_p[FW-1:0];
                    o_prev_wd = (r_ub == NIL) ? r_head[r_uk] : r_mb;
                end
                if (r_ub != NIL) begin
                    o_next_we = 1'b1; o_next_waddr = r_ub[FW-1:0]; o_next_wd = NIL;
                end
                n_state = r_mret;
                if (r_ub == NIL) n_mret = r_mret;
            end
            S_DONE: begin
                // load the output register once the previous word has left
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1; n_state = S_IDLE;
                    n_ostart = r_start; n_ostatus = r_status; n_ocount = r_count;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // unlinked node's prev cleared on its own port when no other prev write
        if (r_state == S_UNL_WR2 && r_ub != NIL && r_p >= NIL) begin
            o_prev_we = 1'b1; o_prev_waddr = r_ub[FW-1:0]; o_prev_wd = NIL;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 11'(NUM_FRAMES)) else $error("allocated frame count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !(r_state == S_DONE)) else $error("ready while finishing");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || i_ready)) |=> r_ovalid)
        else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable({r_ostart, r_ostatus, r_ocount})))
        else $error("result word changed while waiting");
endmodule

>>> hdl/buddy_page_allocator.sv
// Top level of the buddy page allocator.
//  channel | dir | tdata (low bit up)                       | tuser
//  s_axis  | in  | order[1:0], frame_number[11:2], pad      | func[1:0]
//  m_axis  | out | block_start[9:0], allocated_frames[20:10], pad | status[1:0]
// One request at a time; a word rejected at decode goes from S_DECODE to S_DONE and
// then to the output register, and the next is taken back in S_IDLE. Freeing an
// order-3 block (8 frames) checks the mark of each frame (read then compare), clears
// the marks, then relists it. Each split or merge step adds mark writes and link
// updates. After reset the marks and links are swept, one frame a cycle.
// A finished word waits in the output register; with tready low the next request
// still runs, then holds in its last state and the input stalls.
`timescale 1ns / 1ps
module buddy_page_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // order, frame_number
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // block_start, allocated_frames
    output logic [1:0]  m_axis_tuser    // status
);
    import bpa_pkg::*;

    logic          mark_we, next_we, prev_we;
    logic [FW-1:0] mark_addr, next_waddr, next_raddr, prev_waddr, prev_raddr;
    logic [2:0]    mark_wd, mark_rd;
    logic [FW:0]   next_wd, next_rd, prev_wd, prev_rd;
    logic [9:0]    w_start;
    logic [10:0]   w_count;

    assign m_axis_tdata = {3'd0, w_count, w_start};

    bpa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_func(s_axis_tuser), .i_order(s_axis_tdata[1:0]), .i_frame(s_axis_tdata[11:2]),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_start(w_start), .o_status(m_axis_tuser), .o_count(w_count),
        .o_mark_we(mark_we), .o_mark_addr(mark_addr), .o_mark_wd(mark_wd),
        .i_mark_rd(mark_rd),
        .o_next_we(next_we), .o_next_waddr(next_waddr), .o_next_wd(next_wd),
        .o_next_raddr(next_raddr), .i_next_rd(next_rd),
        .o_prev_we(prev_we), .o_prev_waddr(prev_waddr), .o_prev_wd(prev_wd),
        .o_prev_raddr(prev_raddr), .i_prev_rd(prev_rd)
    );

    bpa_datapath u_dp (
        .i_clk(i_clk),
        .i_mark_we(mark_we), .i_mark_addr(mark_addr), .i_mark_wd(mark_wd),
        .o_mark_rd(mark_rd),
        .i_next_we(next_we), .i_next_waddr(next_waddr), .i_next_wd(next_wd),
        .i_next_raddr(next_raddr), .o_next_rd(next_rd),
        .i_prev_we(prev_we), .i_prev_waddr(prev_waddr), .i_prev_wd(prev_wd),
        .i_prev_raddr(prev_raddr), .o_prev_rd(prev_rd)
    );
endmodule

>>> tb/buddy_page_allocator_checker.sv
// Checker for the buddy page allocator: predicts every result word and compares.
`timescale 1ns / 1ps
module buddy_page_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // order[1:0], frame_number[11:2]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // block_start[9:0], allocated_frames[20:10]
    input  logic [1:0]  m_axis_tuser,   // status[1:0]
    output int          o_fail_count,
    output int          o_pending
);
    import bpa_pkg::*;

    localparam int NF  = 1024;
    localparam int NIL = NF;

    typedef struct packed {
        logic [9:0]  start;
        logic [1:0]  status;
        logic [10:0] used;
    } t_outcome;

    logic [2:0] mark [NF];
    int         head [4];
    int         nxt  [NF];
    int         prv  [NF];
    int         used_frames;
    t_outcome   outcome_q[$];

    task automatic pool_init();
        int p;
        p = NIL;
        for (int i = 0; i < NF; i++) begin
            mark[i] = MARK_INNER;
            nxt[i]  = NIL;
            prv[i]  = NIL;
        end
        for (int i = 0; i < 4; i++) head[i] = NIL;
        for (int i = 0; i + 8 <= NF; i += 8) begin
            mark[i] = 3'(3);
            prv[i] = p;
            if (p < NF) nxt[p] = i;
            else head[3] = i;
            p = i;
        end
        used_frames = 0;
    endtask

    task automatic push_free(int k, int f);
        int h;
        h = head[k];
        prv[f] = NIL;
        nxt[f] = h;
        if (h < NF) prv[h] = f;
        head[k] = f;
    endtask

    task automatic drop_free(int k, int f);
        int p, n;
        p = prv[f];
        n = nxt[f];
        if (p < NF) nxt[p] = n;
        else head[k] = n;
        if (n < NF) prv[n] = p;
        nxt[f] = NIL;
        prv[f] = NIL;
    endtask

    task automatic release_block(int b, int k);
        for (int i = 1; i < (1 << k); i++) mark[b + i] = MARK_INNER;
        mark[b] = 3'(k);
        push_free(k, b);
    endtask

    task automatic claim_block(int b, int k);
        for (int i = 0; i < (1 << k); i++) mark[b + i] = MARK_ALLOC;
        used_frames += 1 << k;
    endtask

    task automatic serve_request(logic [1:0] fn, int k, int f);
        t_outcome r;
        int j, b, bud;
        bit ok;
        r = '0;
        r.status = ST_OK;
        if (fn == FN_ALLOC) begin
            j = k;
            while (j < 4 && head[j] >= NF) j++;
            if (j >= 4) r.status = ST_NOBLOCK;
            else begin
                b = head[j];
                drop_free(j, b);
                while (j > k) begin
                    j--;
                    release_block(b + (1 << j), j);
                end
                claim_block(b, k);
                r.start = 10'(b);
            end
        end else if (fn == FN_RESERVE) begin
            ok = 0;
            b = 0;
            for (j = k; j < 4; j++) begin
                b = f & ~((1 << j) - 1);
                if (mark[b] == 3'(j)) begin
                    ok = 1;
                    break;
                end
            end
            if (!ok) r.status = ST_NOBLOCK;
            else begin
                drop_free(j, b);
                while (j > k) begin
                    j--;
                    if (f & (1 << j)) begin
                        release_block(b, j);
                        b += 1 << j;
                    end else release_block(b + (1 << j), j);
                end
                claim_block(b, k);
                r.start = 10'(b);
            end
        end else if (fn == FN_FREE) begin
            ok = (f & ((1 << k) - 1)) == 0 && f + (1 << k) <= NF;
            if (ok)
                for (int i = 0; i < (1 << k); i++)
                    if (mark[f + i] != MARK_ALLOC) ok = 0;
            if (!ok) r.status = ST_BADFRAME;
            else begin
                used_frames -= 1 << k;
                for (int i = 0; i < (1 << k); i++) mark[f + i] = MARK_INNER;
                b = f;
                j = k;
                while (j < 3) begin
                    bud = b ^ (1 << j);
                    if (bud >= NF || mark[bud] != 3'(j)) break;
                    drop_free(j, bud);
                    mark[bud] = MARK_INNER;
                    if (bud < b) b = bud;
                    j++;
                end
                release_block(b, j);
                r.start = 10'(f);
            end
        end else r.status = ST_BADFRAME;
        r.used = 11'(used_frames);
        outcome_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_outcome e;
        if (!i_rst_n) begin
            pool_init();
            outcome_q.delete();
            o_fail_count = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                serve_request(s_axis_tuser, int'(s_axis_tdata[1:0]),
                              int'(s_axis_tdata[11:2]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcome_q.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count++;
                end else begin
                    e = outcome_q[0];
                    outcome_q.delete(0);
                    if (m_axis_tdata[9:0] != e.start) begin
                        $error("block_start: expected %0d, got %0d", e.start,
                               m_axis_tdata[9:0]);
                        o_fail_count++;
                    end
                    if (m_axis_tuser != e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[20:10] != e.used) begin
                        $error("allocated_frames: expected %0d, got %0d", e.used,
                               m_axis_tdata[20:10]);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = outcome_q.size();
    end
endmodule

>>> tb/buddy_page_allocator_test.sv
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module buddy_page_allocator_test;
    import bpa_pkg::*;

    localparam int N_RANDOM = 2000;
    localparam longint CYCLE_LIMIT = 1500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // order[1:0], frame_number[11:2]
    logic [1:0]  s_axis_tuser;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // block_start[9:0], allocated_frames[20:10]
    logic [1:0]  m_axis_tuser;   // status[1:0]
    int          fail_count;
    int          pending;
    longint      cycles;
    int          held_blocks[$];   // starts of blocks we own, order in low 2 bits of key

    buddy_page_allocator u_dut (.*);

    buddy_page_allocator_checker u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // valid drops only when a gap follows, so it is driven once per edge
    task automatic send_word(logic [1:0] fn, logic [1:0] k, logic [9:0] f);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {4'b0, f, k};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // random request: alloc, reserve, free of an owned block usually, a random word sometimes
    task automatic send_random();
        int sel, idx, v;
        logic [1:0] k;
        sel = $urandom_range(0, 99);
        k = 2'($urandom_range(0, 3));
        if (sel < 40) send_word(FN_ALLOC, k, 10'($urandom));
        else if (sel < 65) send_word(FN_RESERVE, k, 10'($urandom));
        else if (sel < 95 && held_blocks.size() > 0) begin
            idx = $urandom_range(0, held_blocks.size() - 1);
            v = held_blocks[idx];
            held_blocks.delete(idx);
            send_word(FN_FREE, 2'(v), 10'(v >> 2));
        end else send_word(2'($urandom_range(0, 3)), k, 10'($urandom));
    endtask

    // track blocks handed out so frees are mostly valid
    logic [1:0] fn_q[$];
    logic [1:0] ord_q[$];
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            fn_q.push_back(s_axis_tuser);
            ord_q.push_back(s_axis_tdata[1:0]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready && fn_q.size() > 0) begin
            if (m_axis_tuser == ST_OK && fn_q[0] != FN_FREE)
                held_blocks.push_back((int'(m_axis_tdata[9:0]) << 2) | int'(ord_q[0]));
            fn_q.delete(0);
            ord_q.delete(0);
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        // long hold-off while requests keep coming
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: edge fields, every func, failure paths, merges
        send_word(FN_FREE, 2'd0, 10'd0);          // free of unallocated frame
        send_word(FN_ALLOC, 2'd0, 10'h3FF);
        send_word(FN_ALLOC, 2'd1, 10'd0);
        send_word(FN_ALLOC, 2'd2, 10'd0);
        send_word(FN_ALLOC, 2'd3, 10'd0);
        send_word(FN_RESERVE, 2'd0, 10'h3FF);
        send_word(FN_RESERVE, 2'd3, 10'd1020);
        send_word(FN_RESERVE, 2'd0, 10'd0);       // already used
        send_word(FN_RESERVE, 2'd1, 10'd5);
        send_word(FN_FREE, 2'd1, 10'd1);          // misaligned
        send_word(FN_FREE, 2'd0, 10'd0);          // merge chain back
        send_word(FN_FREE, 2'd1, 10'd2);
        send_word(FN_FREE, 2'd2, 10'd4);
        send_word(FN_FREE, 2'd2, 10'd4);          // double free
        send_word(2'd3, 2'd3, 10'h3FF);           // unused func
        send_word(FN_FREE, 2'd0, 10'h3FF);
        send_word(FN_FREE, 2'd3, 10'd1016);
        // exhaust the pool, then hit nothing-free
        repeat (130) send_word(FN_ALLOC, 2'd3, 10'd0);
        send_word(FN_ALLOC, 2'd0, 10'd0);
        send_word(FN_RESERVE, 2'd0, 10'd77);
        for (int i = 0; i < N_RANDOM; i++) send_random();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> buddy_page_allocator.f
hdl/bpa_pkg.sv
hdl/bpa_datapath.sv
hdl/bpa_ctrl.sv
hdl/buddy_page_allocator.sv
tb/buddy_page_allocator_checker.sv
tb/buddy_page_allocator_test.sv
